// ===== hdl/nfcs_pkg.sv =====
// ----------------------------------------------------------------------------
// nfcs_pkg
// Shared types and constants of the nearest face centroid search core.
// ----------------------------------------------------------------------------
package nfcs_pkg;

	localparam int unsigned COORD_W   = 32;
	localparam int unsigned IDX_W     = 12;
	localparam int unsigned TOTAL_W   = IDX_W + 1;
	localparam int unsigned CORNER_W  = 3;
	localparam int unsigned CORNERS   = 4;
	localparam int unsigned LIMIT_W   = 17;
	localparam int unsigned SUM_W     = 34;
	localparam int unsigned DIV_CHUNK = 8;
	localparam int unsigned DIV_STEPS = 5;
	localparam int unsigned DIV_W     = DIV_CHUNK * DIV_STEPS;
	localparam int unsigned MAG_W     = 33;
	localparam int unsigned HALF_LO   = 16;
	localparam int unsigned HALF_HI   = MAG_W - HALF_LO;
	localparam int unsigned SQ_W      = 2 * MAG_W - 1;
	localparam int unsigned DIST_W    = SQ_W + 2;
	localparam int unsigned VTX_W     = 3 * COORD_W;
	localparam int unsigned FACE_W    = CORNER_W + CORNERS * IDX_W;
	localparam int unsigned CNT_W     = 3;
	localparam int unsigned APB_AW    = 3;
	localparam int unsigned APB_DW    = 32;

	localparam logic [LIMIT_W-1:0]  LIMIT_RESET = 17'd100000;
	localparam logic [APB_AW-1:0]   ADDR_LIMIT  = 3'd0;
	localparam logic [CORNER_W-1:0] CORNER_MAX  = 3'd4;

	typedef enum logic [1:0] {
		FUNC_VERTEX = 2'd0,
		FUNC_FACE   = 2'd1,
		FUNC_QUERY  = 2'd2
	} func_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FACE,
		ST_CORNER,
		ST_DIV,
		ST_DIFF,
		ST_SQR,
		ST_SUM,
		ST_CMP,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic       clr;
		logic       acc;
		logic       div_load;
		logic       div_step;
		logic       diff;
		logic       sq_issue;
		logic [1:0] sq_sel;
	} lane_ctl_t;

	typedef struct packed {
		logic             valid;
		logic [IDX_W-1:0] index;
	} res_t;

endpackage

// ===== hdl/nfcs_if.sv =====
// ----------------------------------------------------------------------------
// nfcs_if
// Item and result channels of the nearest face centroid search core.
// ----------------------------------------------------------------------------
interface nfcs_in_if import nfcs_pkg::*;;
	logic                      valid;
	logic                      ready;
	logic [1:0]                func;
	logic signed [COORD_W-1:0] coord_x;
	logic signed [COORD_W-1:0] coord_y;
	logic signed [COORD_W-1:0] coord_z;
	logic [CORNER_W-1:0]       corner_count;
	logic [IDX_W-1:0]          corner_a;
	logic [IDX_W-1:0]          corner_b;
	logic [IDX_W-1:0]          corner_c;
	logic [IDX_W-1:0]          corner_d;

	modport source (output valid, func, coord_x, coord_y, coord_z, corner_count,
		corner_a, corner_b, corner_c, corner_d, input ready);
	modport sink (input valid, func, coord_x, coord_y, coord_z, corner_count,
		corner_a, corner_b, corner_c, corner_d, output ready);
endinterface

interface nfcs_out_if import nfcs_pkg::*;;
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] face_index;

	modport source (output valid, face_index, input ready);
	modport sink (input valid, face_index, output ready);
endinterface

// ===== hdl/nfcs_axis.sv =====
// ----------------------------------------------------------------------------
// nfcs_axis
// One coordinate lane: corner sum, division by corner count, squared offset.
// ----------------------------------------------------------------------------
module nfcs_axis import nfcs_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  lane_ctl_t                 ctl,
	input  logic [CORNER_W-1:0]       n,
	input  logic signed [COORD_W-1:0] vtx,
	input  logic signed [COORD_W-1:0] pt,
	output logic [SQ_W-1:0]           sq
);

	function automatic logic [11:0] recip(input logic [CORNER_W-1:0] cnt);
		logic [11:0] r;
		case (cnt)
			3'd2:    r = 12'd1024;
			3'd3:    r = 12'd683;
			3'd4:    r = 12'd512;
			default: r = 12'd2048;
		endcase
		return r;
	endfunction

	function automatic logic [9:0] times_n(input logic [7:0] q,
		input logic [CORNER_W-1:0] cnt);
		logic [9:0] r;
		case (cnt)
			3'd2:    r = {1'b0, q, 1'b0};
			3'd3:    r = {2'b00, q} + {1'b0, q, 1'b0};
			3'd4:    r = {q, 2'b00};
			default: r = {2'b00, q};
		endcase
		return r;
	endfunction

	logic signed [SUM_W-1:0]   sum_q;
	logic                      neg_q;
	logic [DIV_W-1:0]          mag_q;
	logic [DIV_W-1:0]          quo_q;
	logic [1:0]                rem_q;
	logic [MAG_W-1:0]          dmag_q;
	logic [2*HALF_HI-1:0]      prod_q;
	logic [1:0]                psel_q;
	logic                      pv_q;
	logic [SQ_W-1:0]           sq_q;

	logic [SUM_W-1:0]          sum_abs;
	logic [9:0]                dv;
	logic [21:0]               dprod;
	logic [7:0]                q8;
	logic [9:0]                rem_full;
	logic signed [SUM_W:0]     cval;
	logic signed [SUM_W:0]     ptx;
	logic signed [SUM_W:0]     diff;
	logic [SUM_W:0]            dabs;
	logic [HALF_HI-1:0]        op_a;
	logic [HALF_HI-1:0]        op_b;
	logic [2*HALF_HI-1:0]      mprod;
	logic [SQ_W-1:0]           addend;

	assign sum_abs  = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
	assign dv       = {rem_q, mag_q[DIV_W-1 -: DIV_CHUNK]};
	assign dprod    = dv * recip(n);
	assign q8       = dprod[18:11];
	assign rem_full = dv - times_n(q8, n);

	assign cval = neg_q ? -$signed({1'b0, quo_q[SUM_W-1:0]})
		: $signed({1'b0, quo_q[SUM_W-1:0]});
	assign ptx  = (SUM_W+1)'(pt);
	assign diff = cval - ptx;
	assign dabs = diff[SUM_W] ? (SUM_W+1)'(-diff) : (SUM_W+1)'(diff);

	always_comb begin
		case (ctl.sq_sel)
			2'd0: begin
				op_a = {1'b0, dmag_q[HALF_LO-1:0]};
				op_b = {1'b0, dmag_q[HALF_LO-1:0]};
			end
			2'd1: begin
				op_a = dmag_q[MAG_W-1:HALF_LO];
				op_b = {1'b0, dmag_q[HALF_LO-1:0]};
			end
			default: begin
				op_a = dmag_q[MAG_W-1:HALF_LO];
				op_b = dmag_q[MAG_W-1:HALF_LO];
			end
		endcase
	end

	assign mprod = op_a * op_b;

	always_comb begin
		case (psel_q)
			2'd0:    addend = SQ_W'(prod_q);
			2'd1:    addend = SQ_W'(prod_q) << (HALF_LO + 1);
			default: addend = SQ_W'(prod_q) << (2 * HALF_LO);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q <= 1'b0;
		end else begin
			pv_q <= ctl.sq_issue;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.clr) begin
			sum_q <= '0;
		end else if (ctl.acc) begin
			sum_q <= sum_q + SUM_W'(vtx);
		end
		if (ctl.div_load) begin
			neg_q <= sum_q[SUM_W-1];
			mag_q <= DIV_W'(sum_abs);
			quo_q <= '0;
			rem_q <= '0;
		end else if (ctl.div_step) begin
			mag_q <= mag_q << DIV_CHUNK;
			quo_q <= {quo_q[DIV_W-DIV_CHUNK-1:0], q8};
			rem_q <= rem_full[1:0];
		end
		if (ctl.diff) begin
			dmag_q <= dabs[MAG_W-1:0];
			sq_q   <= '0;
		end else if (pv_q) begin
			sq_q <= sq_q + addend;
		end
		prod_q <= mprod;
		psel_q <= ctl.sq_sel;
	end

	assign sq = sq_q;

endmodule

// ===== hdl/nfcs_engine.sv =====
// ----------------------------------------------------------------------------
// nfcs_engine
// Vertex and face stores, append handling and the face walk sequencer.
// ----------------------------------------------------------------------------
module nfcs_engine import nfcs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	nfcs_in_if.sink            in_ch,
	input  logic [LIMIT_W-1:0] limit,
	input  logic               res_take,
	output res_t               res
);

	logic [VTX_W-1:0]  vmem [2**IDX_W];
	logic [FACE_W-1:0] fmem [2**IDX_W];

	state_t                    state_q, state_d;
	logic [CNT_W-1:0]          cnt_q;
	logic [IDX_W-1:0]          f_q;
	logic [TOTAL_W-1:0]        vtotal_q;
	logic [TOTAL_W-1:0]        ftotal_q;
	logic [VTX_W-1:0]          vdata_q;
	logic [FACE_W-1:0]         face_q;
	logic signed [COORD_W-1:0] px_q, py_q, pz_q;
	logic [DIST_W-1:0]         best_q;
	logic [DIST_W-1:0]         dist_q;
	logic [IDX_W-1:0]          best_idx_q;

	logic                      accept;
	logic [CORNER_W-1:0]       n_in;
	logic [CORNER_W-1:0]       n_face;
	logic [IDX_W-1:0]          vaddr;
	logic [2*LIMIT_W-1:0]      lim_sq;
	logic                      more;
	lane_ctl_t                 ctl;
	logic [SQ_W-1:0]           sq_x, sq_y, sq_z;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign accept      = in_ch.valid && in_ch.ready;
	assign n_in = (in_ch.corner_count == '0) ? CORNER_W'(1)
		: (in_ch.corner_count > CORNER_MAX) ? CORNER_MAX : in_ch.corner_count;
	assign n_face = face_q[FACE_W-1 -: CORNER_W];
	assign vaddr  = face_q[cnt_q[1:0]*IDX_W +: IDX_W];
	assign lim_sq = limit * limit;
	assign more   = ({1'b0, f_q} + TOTAL_W'(1)) < ftotal_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && in_ch.func == FUNC_QUERY) begin
					state_d = (ftotal_q > TOTAL_W'(1)) ? ST_FACE : ST_DONE;
				end
			end
			ST_FACE:   state_d = ST_CORNER;
			ST_CORNER: if (cnt_q == n_face) state_d = ST_DIV;
			ST_DIV:    if (cnt_q == CNT_W'(DIV_STEPS)) state_d = ST_DIFF;
			ST_DIFF:   state_d = ST_SQR;
			ST_SQR:    if (cnt_q == CNT_W'(3)) state_d = ST_SUM;
			ST_SUM:    state_d = ST_CMP;
			ST_CMP:    state_d = more ? ST_FACE : ST_DONE;
			ST_DONE:   if (res_take) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		res = '0;
		case (state_q)
			ST_FACE:   ctl.clr = 1'b1;
			ST_CORNER: ctl.acc = (cnt_q != '0);
			ST_DIV: begin
				ctl.div_load = (cnt_q == '0);
				ctl.div_step = (cnt_q != '0);
			end
			ST_DIFF:   ctl.diff = 1'b1;
			ST_SQR: begin
				ctl.sq_issue = (cnt_q != CNT_W'(3));
				ctl.sq_sel   = cnt_q[1:0];
			end
			ST_DONE: begin
				res.valid = 1'b1;
				res.index = best_idx_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			vtotal_q <= '0;
			ftotal_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= (state_d != state_q) ? '0 : cnt_q + CNT_W'(1);
			if (accept && in_ch.func == FUNC_VERTEX && !vtotal_q[IDX_W]) begin
				vtotal_q <= vtotal_q + TOTAL_W'(1);
			end
			if (accept && in_ch.func == FUNC_FACE && !ftotal_q[IDX_W]) begin
				ftotal_q <= ftotal_q + TOTAL_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && in_ch.func == FUNC_VERTEX && !vtotal_q[IDX_W]) begin
			vmem[vtotal_q[IDX_W-1:0]] <= {in_ch.coord_z, in_ch.coord_y, in_ch.coord_x};
		end
		vdata_q <= vmem[vaddr];
	end

	always_ff @(posedge clk) begin
		if (accept && in_ch.func == FUNC_FACE && !ftotal_q[IDX_W]) begin
			fmem[ftotal_q[IDX_W-1:0]] <= {n_in, in_ch.corner_d, in_ch.corner_c,
				in_ch.corner_b, in_ch.corner_a};
		end
		face_q <= fmem[f_q];
	end

	always_ff @(posedge clk) begin
		if (accept && in_ch.func == FUNC_QUERY) begin
			px_q       <= in_ch.coord_x;
			py_q       <= in_ch.coord_y;
			pz_q       <= in_ch.coord_z;
			best_q     <= {1'b0, lim_sq, 32'b0};
			best_idx_q <= '0;
			f_q        <= IDX_W'(1);
		end
		if (state_q == ST_SUM) begin
			dist_q <= DIST_W'(sq_x) + DIST_W'(sq_y) + DIST_W'(sq_z);
		end
		if (state_q == ST_CMP) begin
			if (best_q > dist_q) begin
				best_q     <= dist_q;
				best_idx_q <= f_q;
			end
			f_q <= f_q + IDX_W'(1);
		end
	end

	nfcs_axis u_axis_x (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.n      (n_face),
		.vtx    (vdata_q[COORD_W-1:0]),
		.pt     (px_q),
		.sq     (sq_x)
	);

	nfcs_axis u_axis_y (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.n      (n_face),
		.vtx    (vdata_q[2*COORD_W-1:COORD_W]),
		.pt     (py_q),
		.sq     (sq_y)
	);

	nfcs_axis u_axis_z (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.n      (n_face),
		.vtx    (vdata_q[3*COORD_W-1:2*COORD_W]),
		.pt     (pz_q),
		.sq     (sq_z)
	);

endmodule

// ===== hdl/nearest_face_centroid_search_core.sv =====
// ----------------------------------------------------------------------------
// nearest_face_centroid_search_core
// Append vertices and faces, then query the face whose centroid lies nearest.
// ----------------------------------------------------------------------------
// Appends are taken while the engine is idle. A query walks stored faces 1 to
// N-1 through one shared sequencer; each face passes through one face store
// read, one vertex store read per corner, a five-step byte divider, three
// partial-product squaring steps, a sum and a compare. The result sits in an
// output register; the next item is taken while it waits. No clearing pass
// after reset.
module nearest_face_centroid_search_core import nfcs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	nfcs_in_if.sink           in_ch,
	nfcs_out_if.source        out_ch,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	logic [LIMIT_W-1:0] limit_q;
	logic               out_valid_q;
	logic [IDX_W-1:0]   out_index_q;
	logic               res_take;
	logic               wr_limit;
	res_t               res;

	assign pready   = 1'b1;
	assign wr_limit = psel && penable && pwrite && (paddr == ADDR_LIMIT);
	assign prdata   = (paddr == ADDR_LIMIT) ? APB_DW'(limit_q) : '0;
	assign res_take = res.valid && (!out_valid_q || out_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q     <= LIMIT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (wr_limit) begin
				limit_q <= pwdata[LIMIT_W-1:0];
			end
			if (res_take) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_index_q <= res.index;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.face_index = out_index_q;

	nfcs_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.limit    (limit_q),
		.res_take (res_take),
		.res      (res)
	);

	a_no_accept_while_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |-> !res.valid)
		else $error("transaction accepted while a result is pending");

	a_limit_only_on_write: assert property (@(posedge clk) disable iff (!arst_n)
		!wr_limit |=> $stable(limit_q))
		else $error("distance limit changed without a write");

	a_out_from_engine: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_ch.valid) |-> $past(res.valid))
		else $error("output valid without an engine result");

endmodule
